### sv/cbp_pkg.sv
// Shared constants and types for the context Huffman bit packer.
`default_nettype none
package cbp_pkg;

   localparam int CBP_MAX_CODE_LEN = 32;
   localparam int CBP_LEN_LIMIT    = (CBP_MAX_CODE_LEN > 32) ? 32 : CBP_MAX_CODE_LEN;
   localparam int CBP_ADDR_W       = 16;
   localparam int CBP_DEPTH        = 1 << CBP_ADDR_W;
   localparam int CBP_LEN_W        = 6;
   localparam int CBP_CODE_W       = 32;
   localparam int CBP_BUF_W        = CBP_CODE_W + 8;
   localparam int CBP_TOTAL_W      = 6;
   localparam int CBP_REQ_DATA_W   = 56;

   localparam logic [7:0] CBP_START_CONTEXT_RESET = 8'h66;

   typedef enum logic {
      CBP_OP_LOAD   = 1'b0,
      CBP_OP_ENCODE = 1'b1
   } cbp_op_type;

   // Codeword looked up for one encode, handed from lookup to packer.
   typedef struct packed {
      logic                   valid;
      logic                   eoe;
      logic [CBP_LEN_W-1:0]   len;
      logic [CBP_CODE_W-1:0]  code;
   } cbp_lookup_type;

endpackage
`default_nettype wire

### sv/cbp_lookup.sv
// Codeword table, context tracking and clearing pass of the bit packer.
`default_nettype none
module cbp_lookup (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [cbp_pkg::CBP_REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                                 req_tlast,
   input  wire logic                                 req_tuser,
   input  wire logic [7:0]                           start_context,
   input  wire logic                                 take,
   output cbp_pkg::cbp_lookup_type                   item
);
   import cbp_pkg::*;

   logic [CBP_LEN_W+CBP_CODE_W-1:0] mem [CBP_DEPTH];

   logic                            clear_ff, clear_in;
   logic [CBP_ADDR_W-1:0]           clear_cnt_ff, clear_cnt_in;
   logic [7:0]                      ctx_ff, ctx_in;
   logic                            valid_ff, valid_in;
   logic                            eoe_ff;
   logic [CBP_LEN_W+CBP_CODE_W-1:0] rdata_ff;

   logic                            accept;
   cbp_op_type                      op;
   logic [7:0]                      f_ctx, f_sym;
   logic [CBP_LEN_W-1:0]            f_len;
   logic [CBP_CODE_W-1:0]           f_code;
   logic                            wr_en;
   logic [CBP_ADDR_W-1:0]           wr_addr;
   logic [CBP_LEN_W+CBP_CODE_W-1:0] wr_data;
   logic                            rd_en;

   assign op     = cbp_op_type'(req_tuser);
   assign f_ctx  = req_tdata[7:0];
   assign f_sym  = req_tdata[15:8];
   assign f_len  = req_tdata[21:16];
   assign f_code = req_tdata[53:22];

   assign req_tready = !clear_ff && (!valid_ff || take);
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = accept && (op == CBP_OP_ENCODE);

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = {f_ctx, f_sym};
      wr_data      = {f_len, f_code};
      if (clear_ff) begin
         wr_en        = 1'b1;
         wr_addr      = clear_cnt_ff;
         wr_data      = '0;
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == {CBP_ADDR_W{1'b1}}) begin
            clear_in = 1'b0;
         end
      end else if (accept && (op == CBP_OP_LOAD) && (f_len <= CBP_LEN_W'(CBP_LEN_LIMIT))) begin
         wr_en = 1'b1;
      end

      ctx_in = ctx_ff;
      if (rd_en) begin
         ctx_in = req_tlast ? start_context : f_sym;
      end

      valid_in = valid_ff;
      if (rd_en) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         ctx_ff       <= CBP_START_CONTEXT_RESET;
         valid_ff     <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         ctx_ff       <= ctx_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         eoe_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[{ctx_ff, f_sym}];
      end
   end

   assign item.valid = valid_ff;
   assign item.eoe   = eoe_ff;
   assign item.len   = rdata_ff[CBP_LEN_W+CBP_CODE_W-1:CBP_CODE_W];
   assign item.code  = rdata_ff[CBP_CODE_W-1:0];

endmodule
`default_nettype wire

### sv/cbp_packer.sv
// Bit packer: merges codewords with the partial byte and emits full bytes.
`default_nettype none
module cbp_packer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cbp_pkg::cbp_lookup_type  item,
   output logic                          take,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);
   import cbp_pkg::*;

   logic                     active_ff, active_in;
   logic [CBP_BUF_W-1:0]     buf_ff, buf_in;
   logic [CBP_TOTAL_W-1:0]   total_ff, total_in;
   logic                     eoe_ff, eoe_in;
   logic [7:0]               pend_ff, pend_in;
   logic [2:0]               pcount_ff, pcount_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic [CBP_BUF_W-1:0]     code_left, merged;
   logic [CBP_TOTAL_W-1:0]   merged_total;
   logic                     cur_valid, cur_eoe;
   logic [CBP_BUF_W-1:0]     cur_buf, nbuf;
   logic [CBP_TOTAL_W-1:0]   cur_total, ntotal;
   logic                     emit, last, out_can, done;

   assign take    = !active_ff;
   assign out_can = !rsp_valid_ff || rsp_tready;

   always_comb begin
      // Left-align the codeword; bits above its length fall off the top.
      code_left = '0;
      if (item.len != '0) begin
         code_left = {item.code, 8'h00} << (CBP_LEN_W'(CBP_CODE_W) - item.len);
      end
      merged       = {pend_ff, {CBP_CODE_W{1'b0}}} | (code_left >> pcount_ff);
      merged_total = CBP_TOTAL_W'(pcount_ff) + CBP_TOTAL_W'(item.len);

      if (active_ff) begin
         cur_valid = 1'b1;
         cur_buf   = buf_ff;
         cur_total = total_ff;
         cur_eoe   = eoe_ff;
      end else begin
         cur_valid = item.valid;
         cur_buf   = merged;
         cur_total = merged_total;
         cur_eoe   = item.eoe;
      end

      // Pick the next byte: a full one, else a padded tail at entry end.
      emit   = 1'b0;
      last   = 1'b0;
      nbuf   = cur_buf;
      ntotal = cur_total;
      if (cur_total >= CBP_TOTAL_W'(8)) begin
         emit   = 1'b1;
         nbuf   = cur_buf << 8;
         ntotal = cur_total - CBP_TOTAL_W'(8);
         last   = (ntotal < CBP_TOTAL_W'(8)) && !(cur_eoe && (ntotal != '0));
      end else if (cur_eoe && (cur_total != '0)) begin
         emit   = 1'b1;
         last   = 1'b1;
         nbuf   = '0;
         ntotal = '0;
      end

      done = cur_valid && (!emit || (out_can && last));

      active_in = cur_valid && !done;
      buf_in    = cur_buf;
      total_in  = cur_total;
      eoe_in    = cur_eoe;
      if (emit && out_can) begin
         buf_in   = nbuf;
         total_in = ntotal;
      end

      pend_in   = pend_ff;
      pcount_in = pcount_ff;
      if (done) begin
         pend_in   = cur_eoe ? 8'h00 : nbuf[CBP_BUF_W-1:CBP_BUF_W-8];
         pcount_in = cur_eoe ? 3'd0 : ntotal[2:0];
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (cur_valid && emit && out_can) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cur_buf[CBP_BUF_W-1:CBP_BUF_W-8];
         rsp_last_in  = last;
         rsp_done_in  = last && cur_eoe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pend_ff      <= '0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      total_ff    <= total_in;
      eoe_ff      <= eoe_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule
`default_nettype wire

### sv/context_huffman_bit_packer_top.sv
// Top level of the order-1 context Huffman encoder with bit packer.
//
// Channels: req_ takes load and encode items, rsp_ delivers packed bytes,
// csr_ writes the start context (taken in every cycle, even during clear).
// A load with length up to 32 writes one codeword into a 65536-entry table
// under (context, symbol); an encode looks up its symbol under the current
// previous byte and appends the codeword MSB-first to the byte packer.
// The first byte of an encode passes one register for the table read and
// one for the output byte before it can transfer on rsp_.
// Throughput: one item per cycle while each item emits at most one byte and
// the receiver keeps up; bytes leave at one per cycle while it keeps up,
// and an item emitting more than one byte holds the packer until its last
// byte is registered. The single output register sets this byte rate.
// Reset: a clearing pass writes zero length into every table entry, one
// entry a cycle; req_tready stays low during it.
// Stall: with rsp_tready low the pending byte holds, an item with a byte to
// emit stalls the packer; one looked-up item waits before req_tready drops.
`default_nettype none
module context_huffman_bit_packer_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tdata: context_byte[7:0], symbol[15:8], code_length[21:16],
   // code_bits[53:22], zero fill[55:54]
   input  wire logic [cbp_pkg::CBP_REQ_DATA_W-1:0] req_tdata,
   // tuser: op
   input  wire logic                               req_tuser,
   input  wire logic                               req_tlast,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: packed_byte[7:0]
   output logic [7:0]                              rsp_tdata,
   // tuser: entry_done
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [7:0]                         csr_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready
);
   import cbp_pkg::*;

   logic [7:0]     start_context_ff, start_context_in;
   cbp_lookup_type item;
   logic           take;

   // Hold the start context; a write lands at the next entry start.
   assign csr_ready = 1'b1;

   always_comb begin
      start_context_in = start_context_ff;
      if (csr_valid && csr_ready) begin
         start_context_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_context_ff <= CBP_START_CONTEXT_RESET;
      end else begin
         start_context_ff <= start_context_in;
      end
   end

   // Table lookup stage: clear pass, loads, context tracking.
   cbp_lookup u_lookup (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tuser     (req_tuser),
      .start_context (start_context_ff),
      .take          (take),
      .item          (item)
   );

   // Packer stage: merge, split into bytes, drive the output register.
   cbp_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
